FILE: sv/srtf_job_scheduler_core_assert.svh
// Assertion macros for the SRTF scheduler.
// Uses clk and rst_n of the including module.
`ifndef SRTF_JOB_SCHEDULER_CORE_ASSERT_SVH
`define SRTF_JOB_SCHEDULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtf assertion failed");
`define SRTF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtf assertion failed");
`else
`define SRTF_ASSERT_NOW(label, ante, cons)
`define SRTF_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: sv/srtf_pkg.sv
// Package for the SRTF scheduler: sizes, status codes, chain token type.
// No dependencies.
package srtf_pkg;
  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int ID_W     = 6;
  localparam int BURST_W  = 12;
  localparam int TIME_W   = 32;
  localparam int STAT_W   = 3;

  localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO      = 3'd2;
  localparam logic [STAT_W-1:0] ST_IDLE_TICK = 3'd3;
  localparam logic [STAT_W-1:0] ST_RAN       = 3'd4;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Token passed cell to cell. pend: arrive = not yet placed,
  // tick = a candidate has been found.
  typedef struct packed {
    logic               vld;
    logic               act;
    logic               pend;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] left;
    logic [TIME_W-1:0]  age;
    logic [SLOT_W-1:0]  slot;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } run_cmd_t;
endpackage

FILE: sv/srtf_ifs.sv
// Valid/ready channel interfaces for the SRTF scheduler.
// Depends on srtf_pkg.
interface srtf_in_if;
  import srtf_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    job_id;
  logic [BURST_W-1:0] job_burst;
  modport source (output valid, action, job_id, job_burst, input ready);
  modport sink   (input valid, action, job_id, job_burst, output ready);
endinterface

interface srtf_out_if;
  import srtf_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    run_id;
  logic               finished;
  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  waiting;
  modport source (output valid, status, run_id, finished, turnaround, waiting,
                  input ready);
  modport sink   (input valid, status, run_id, finished, turnaround, waiting,
                  output ready);
endinterface

FILE: sv/srtf_cell.sv
// One job slot of the scheduler chain: holds the slot state, places
// arrivals and folds itself into the running best candidate. Uses srtf_pkg.
module srtf_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [srtf_pkg::SLOT_W-1:0] my_idx,
  input  logic [srtf_pkg::TIME_W-1:0] now_time,
  input  srtf_pkg::run_cmd_t        run,
  input  srtf_pkg::tok_t            tok_i,
  output srtf_pkg::tok_t            tok_o
);
  import srtf_pkg::*;

  logic               used_r;
  logic [ID_W-1:0]    id_r;
  logic [BURST_W-1:0] burst_r;
  logic [BURST_W-1:0] left_r;
  logic [TIME_W-1:0]  arrival_r;
  tok_t               tok_r, tok_nxt;
  logic [TIME_W-1:0]  age_w;
  logic               own_better, place, hit;

  assign age_w = now_time - arrival_r;

  // strict order: incoming (lower slot) wins a full tie
  assign own_better = used_r && (!tok_i.pend || (left_r < tok_i.left) ||
                      ((left_r == tok_i.left) && ((age_w > tok_i.age) ||
                      ((age_w == tok_i.age) && (id_r < tok_i.id)))));
  assign place = tok_i.vld && (tok_i.act == ACT_ARRIVE) && tok_i.pend && !used_r;
  assign hit   = run.en && (run.slot == my_idx);

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && (tok_i.act == ACT_TICK) && own_better) begin
      tok_nxt.pend  = 1'b1;
      tok_nxt.id    = id_r;
      tok_nxt.burst = burst_r;
      tok_nxt.left  = left_r;
      tok_nxt.age   = age_w;
      tok_nxt.slot  = my_idx;
    end
    if (place) begin
      tok_nxt.pend = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (place) begin
        used_r <= 1'b1;
      end else if (hit && (left_r == BURST_W'(1))) begin
        used_r <= 1'b0;
      end
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (place) begin
      id_r      <= tok_i.id;
      burst_r   <= tok_i.burst;
      left_r    <= tok_i.burst;
      arrival_r <= now_time;
    end else if (hit) begin
      left_r <= left_r - BURST_W'(1);
    end
  end

  assign tok_o = tok_r;
endmodule

FILE: sv/srtf_job_scheduler_core.sv
// Shortest-remaining-time-first scheduler, top level.
// Depends on srtf_pkg, srtf_ifs, srtf_cell and the assertion header.
//
// Each job slot is one cell of a chain of MAX_JOBS cells. An accepted item
// injects a token at the head of the chain; the token moves one cell per
// clock. An arrive token is claimed by the first free cell it passes (the
// lowest free slot); a tick token collects the best candidate (least time
// left, then oldest arrival, then lowest id, then lowest slot). When the
// token leaves the tail, a tick runs its winning cell (if any) one unit and
// steps the time counter; the result item is built in S_RES and held in
// S_OUT. The time from accept to result valid is set by the length of the
// chain; an arrival with zero burst skips the chain and its result is
// registered on accept. The block takes one item at a time: in_ch.ready is
// high only while no item is in work and the previous result has been
// taken. A result waits in the output register until out_ch.ready. No
// clearing pass is needed after reset: of the slot state, only the used
// flags are reset.
module srtf_job_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  srtf_in_if.sink    in_ch,
  srtf_out_if.source out_ch
);
  import srtf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [TIME_W-1:0]  now_r;
  tok_t               inj_r;
  tok_t               fin_r;     // token captured at the tail
  tok_t               chain [MAX_JOBS+1];
  run_cmd_t           run;
  logic [TIME_W-1:0]  turn_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r;
  logic [ID_W-1:0]    run_id_r;
  logic               finished_r;
  logic [TIME_W-1:0]  turnaround_r;
  logic [TIME_W-1:0]  waiting_r;

  logic               in_acc, out_acc, zero_burst;
  logic               done_flag;
  logic               fin_tick;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;
  assign zero_burst  = (in_ch.action == ACT_ARRIVE) && (in_ch.job_burst == '0);

  // ---- chain of slot cells ----
  assign chain[0] = inj_r;

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    srtf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (SLOT_W'(k)),
      .now_time (now_r),
      .run      (run),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1])
    );
  end

  // run the winner one unit while in FIN
  assign run.en   = (state_r == S_FIN) && (fin_r.act == ACT_TICK) && fin_r.pend;
  assign run.slot = fin_r.slot;

  assign done_flag = (fin_r.left == BURST_W'(1));
  assign fin_tick  = (state_r == S_FIN) && (fin_r.act == ACT_TICK);

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = zero_burst ? S_OUT : S_SCAN;
      S_SCAN: if (chain[MAX_JOBS].vld) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_RES;
      S_RES:  state_nxt = S_OUT;
      S_OUT:  if (out_acc) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      inj_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // injection lasts one cycle
      inj_r.vld <= in_acc && !zero_burst;
      if (in_acc) begin
        inj_r.act   <= in_ch.action;
        inj_r.pend  <= (in_ch.action == ACT_ARRIVE);
        inj_r.id    <= in_ch.job_id;
        inj_r.burst <= in_ch.job_burst;
        inj_r.left  <= '0;
        inj_r.age   <= '0;
        inj_r.slot  <= '0;
      end
      if (fin_tick) begin
        now_r <= now_r + TIME_W'(1);
      end
      if (state_r == S_IDLE && in_acc && zero_burst) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_RES) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && chain[MAX_JOBS].vld) begin
      fin_r <= chain[MAX_JOBS];
    end
    // finish time minus arrival equals age plus the tick just run
    if (state_r == S_FIN) begin
      turn_r <= fin_r.age + TIME_W'(1);
    end
    if (state_r == S_IDLE && in_acc && zero_burst) begin
      status_r     <= ST_ZERO;
      run_id_r     <= '0;
      finished_r   <= 1'b0;
      turnaround_r <= '0;
      waiting_r    <= '0;
    end else if (state_r == S_RES) begin
      run_id_r     <= '0;
      finished_r   <= 1'b0;
      turnaround_r <= '0;
      waiting_r    <= '0;
      if (fin_r.act == ACT_ARRIVE) begin
        status_r <= fin_r.pend ? ST_FULL : ST_ACCEPTED;
      end else if (!fin_r.pend) begin
        status_r <= ST_IDLE_TICK;
      end else begin
        status_r <= ST_RAN;
        run_id_r <= fin_r.id;
        if (done_flag) begin
          finished_r   <= 1'b1;
          turnaround_r <= turn_r;
          waiting_r    <= turn_r - TIME_W'(fin_r.burst);
        end
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.run_id     = run_id_r;
  assign out_ch.finished   = finished_r;
  assign out_ch.turnaround = turnaround_r;
  assign out_ch.waiting    = waiting_r;

  // ---- checks ----
`include "srtf_job_scheduler_core_assert.svh"
  `SRTF_ASSERT_NOW(a_tail_only_in_scan, chain[MAX_JOBS].vld, state_r == S_SCAN)
  `SRTF_ASSERT_NOW(a_no_take_while_result, out_valid_r, !in_ch.ready)
  `SRTF_ASSERT_NXT(a_tick_steps_time, fin_tick, now_r == $past(now_r) + TIME_W'(1))
  `SRTF_ASSERT_NOW(a_finish_only_on_run, out_valid_r && finished_r, status_r == ST_RAN)
endmodule

FILE: tb/sv/srtf_job_scheduler_core_tb.sv
`timescale 1ns / 1ps
// Testbench for srtf_job_scheduler_core: directed and random arrive/tick items,
// each result checked field by field against a job-table predictor kept here.
// Depends on srtf_pkg, srtf_ifs (srtf_in_if, srtf_out_if) and the scheduler RTL.
module srtf_job_scheduler_core_tb;
  import srtf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off in the pressure test
  localparam int SETTLE_CYCLES  = 2 * (MAX_JOBS + 4) + 10;
  localparam int MAX_PRINTS     = 100;
  localparam int ID_MAX         = 35;

  // One expected result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   run_id;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } sched_result_t;

  logic clk;
  logic rst_n;

  srtf_in_if  in_ch ();
  srtf_out_if out_ch ();

  srtf_job_scheduler_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted job table. Entries other than job_live are only read for live slots.
  logic               job_live  [MAX_JOBS];
  logic [ID_W-1:0]    job_tag   [MAX_JOBS];
  logic [BURST_W-1:0] job_need  [MAX_JOBS];
  logic [BURST_W-1:0] job_rem   [MAX_JOBS];
  logic [TIME_W-1:0]  job_start [MAX_JOBS];
  logic [TIME_W-1:0]  clock_now;

  sched_result_t     pending [$];   // results still owed by the block, oldest first
  logic [STAT_W-1:0] last_status;

  bit in_offer;   // in_ch.valid was last driven high
  bit no_idle;    // both sides run flat out
  bit hold_req;   // ask the receiver for a long hold-off

  int mismatch_count;
  int quiet_cycles;
  int n_sent, n_checked, n_done, n_full, n_zero, n_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Slot a goes ahead of slot b: less time left, then older (age taken modulo
  // 2^32 so wrap of the time counter keeps the order), then lower id.
  function automatic bit goes_first(int a, int b);
    logic [TIME_W-1:0] age_a, age_b;
    age_a = clock_now - job_start[a];
    age_b = clock_now - job_start[b];
    if (job_rem[a] != job_rem[b]) return job_rem[a] < job_rem[b];
    if (age_a != age_b) return age_a > age_b;
    return job_tag[a] < job_tag[b];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int k = 0; k < MAX_JOBS; k++) if (job_live[k]) n++;
    return n;
  endfunction

  function automatic sched_result_t predict_schedule(logic act, logic [ID_W-1:0] id,
                                                     logic [BURST_W-1:0] burst);
    sched_result_t r;
    int pick;
    r    = '0;
    pick = -1;
    if (act == ACT_ARRIVE) begin
      // Zero burst is turned away before the table is even looked at.
      if (burst == '0) begin
        r.status = ST_ZERO;
      end else begin
        for (int k = 0; k < MAX_JOBS; k++) if (!job_live[k] && pick < 0) pick = k;
        if (pick < 0) begin
          r.status = ST_FULL;
        end else begin
          job_live[pick]  = 1'b1;
          job_tag[pick]   = id;
          job_need[pick]  = burst;
          job_rem[pick]   = burst;
          job_start[pick] = clock_now;
          r.status        = ST_ACCEPTED;
        end
      end
    end else begin
      // Strict comparison keeps the lower slot on a full tie.
      for (int k = 0; k < MAX_JOBS; k++)
        if (job_live[k] && (pick < 0 || goes_first(k, pick))) pick = k;
      clock_now = clock_now + TIME_W'(1);
      if (pick < 0) begin
        r.status = ST_IDLE_TICK;
      end else begin
        job_rem[pick] = job_rem[pick] - BURST_W'(1);
        r.status      = ST_RAN;
        r.run_id      = job_tag[pick];
        if (job_rem[pick] == '0) begin
          r.finished     = 1'b1;
          r.turnaround   = clock_now - job_start[pick];
          r.waiting      = r.turnaround - TIME_W'(job_need[pick]);
          job_live[pick] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Mostly back to back, often a few cycles, now and then a long gap.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Offer one item, wait for the handshake, queue its expected result. With no
  // gap, valid stays high and the caller's next item follows at once.
  task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                           input logic [BURST_W-1:0] burst);
    sched_result_t want;
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.job_id    <= id;
    in_ch.job_burst <= burst;
    in_offer = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    want = predict_schedule(act, id, burst);
    pending = {pending, want};
    last_status = want.status;
    n_sent++;
    if (want.status == ST_FULL)      n_full++;
    if (want.status == ST_ZERO)      n_zero++;
    if (want.status == ST_IDLE_TICK) n_idle++;
    if (want.finished)               n_done++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_offer = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Tick with random content in the fields a tick ignores.
  task automatic send_tick();
    send_item(ACT_TICK, ID_W'($urandom_range(0, ID_MAX)), BURST_W'($urandom_range(0, 4095)));
  endtask

  // Stop offering and wait for every owed result. Each item yields exactly one
  // result, so an empty queue means the block is idle.
  task automatic drain_results();
    if (in_offer) begin
      in_ch.valid <= 1'b0;
      in_offer = 1'b0;
    end
    while (pending.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] wanted);
    mismatch_count++;
    // Quiet after the first hundred so a broken block cannot flood the log.
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] result %0d: %s is %0d, predicted %0d",
               $realtime, n_checked, field, got, wanted);
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (pending.size() == 0) begin
        report_mismatch("unrequested result, status", TIME_W'(out_ch.status), '0);
      end else begin
        want = pending.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", TIME_W'(out_ch.status), TIME_W'(want.status));
        if (out_ch.run_id !== want.run_id)
          report_mismatch("run_id", TIME_W'(out_ch.run_id), TIME_W'(want.run_id));
        if (out_ch.finished !== want.finished)
          report_mismatch("finished", TIME_W'(out_ch.finished), TIME_W'(want.finished));
        if (out_ch.turnaround !== want.turnaround)
          report_mismatch("turnaround", out_ch.turnaround, want.turnaround);
        if (out_ch.waiting !== want.waiting)
          report_mismatch("waiting", out_ch.waiting, want.waiting);
      end
    end
  end

  // Ends a hung run: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d quiet cycles, %0d results owed", quiet_cycles, pending.size());
      $display("srtf_job_scheduler_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks on an empty table: idle status, time still moves.
  task automatic test_idle_tick();
    send_tick();
    send_tick();
    drain_results();
  endtask

  // Zero burst is refused and leaves the table alone.
  task automatic test_zero_burst();
    send_item(ACT_ARRIVE, ID_W'(ID_MAX), '0);
    send_item(ACT_ARRIVE, '0, '0);
    drain_results();
  endtask

  // Equal time left and age: lower id first; equal ids too: lower slot first.
  // Then a later arrival with the same time left loses to the older job.
  task automatic test_tie_breaks();
    send_item(ACT_ARRIVE, ID_W'(20), BURST_W'(2));
    send_item(ACT_ARRIVE, ID_W'(7),  BURST_W'(2));
    send_item(ACT_ARRIVE, ID_W'(7),  BURST_W'(2));
    send_tick();
    send_item(ACT_ARRIVE, ID_W'(1),  BURST_W'(1));
    send_tick();
    drain_results();
  endtask

  // Fill every slot (with the id extremes and one longer job), then arrive on
  // a full table with the largest burst, then zero burst on a full table,
  // which must report zero burst.
  task automatic test_table_full();
    int k;
    k = 0;
    while (live_count() < MAX_JOBS) begin
      case (k)
        0:       send_item(ACT_ARRIVE, '0, BURST_W'(40));
        1:       send_item(ACT_ARRIVE, ID_W'(ID_MAX), BURST_W'(1));
        default: send_item(ACT_ARRIVE, ID_W'($urandom_range(0, ID_MAX)),
                           BURST_W'($urandom_range(2, 9)));
      endcase
      k++;
    end
    send_item(ACT_ARRIVE, ID_W'(12), BURST_W'(4095));
    send_item(ACT_ARRIVE, '0, '0);
    send_tick();
    drain_results();
  endtask

  // Tick until the table is empty; the longer job runs last and gives the
  // largest turnaround and waiting of this stretch.
  task automatic test_long_job();
    no_idle = 1'b1;
    while (live_count() > 0) send_tick();
    no_idle = 1'b0;
    drain_results();
  endtask

  // Receiver holds off for a long stretch while items keep coming: the block
  // fills and must stall its input without losing or reordering anything.
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) send_item(ACT_ARRIVE, ID_W'($urandom_range(0, ID_MAX)), BURST_W'(2));
      else            send_tick();
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  // Random arrive/tick mix. Ticks grow likelier as the table fills so jobs
  // keep turning over; short bursts dominate, with some zero, some long,
  // and now and then a flood of arrivals that runs into a full table.
  task automatic test_random_mix(input int count, input bit flat_out);
    int n;
    int r;
    logic [BURST_W-1:0] burst;
    no_idle = flat_out;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 2) begin
        do begin
          send_item(ACT_ARRIVE, ID_W'($urandom_range(0, ID_MAX)),
                    BURST_W'($urandom_range(1, 6)));
          n++;
        end while (last_status != ST_FULL);
      end else if ($urandom_range(0, 99) < 30 + 4 * live_count()) begin
        send_tick();
        n++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)       burst = '0;
        else if (r < 75) burst = BURST_W'($urandom_range(1, 6));
        else if (r < 97) burst = BURST_W'($urandom_range(7, 40));
        else             burst = BURST_W'($urandom_range(0, 300));
        send_item(ACT_ARRIVE, ID_W'($urandom_range(0, ID_MAX)), burst);
        n++;
      end
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_all
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ARRIVE;
    in_ch.job_id    = '0;
    in_ch.job_burst = '0;
    in_offer        = 1'b0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    n_sent = 0; n_checked = 0; n_done = 0; n_full = 0; n_zero = 0; n_idle = 0;
    last_status     = ST_ACCEPTED;
    clock_now       = '0;
    for (int k = 0; k < MAX_JOBS; k++) job_live[k] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_tick();
    test_zero_burst();
    test_tie_breaks();
    test_table_full();
    test_long_job();
    test_backpressure();
    test_random_mix(160, 1'b0);
    test_random_mix(160, 1'b1);
    test_random_mix(160, 1'b0);

    // All results are in; let any late extra result show up.
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d results checked): %0d idle ticks, tie-breaks,",
             n_sent, n_checked, n_idle);
    $display("rejects (%0d zero burst / %0d full), a long hold-off, %0d job completions",
             n_zero, n_full, n_done);
    if (mismatch_count == 0 && pending.size() == 0) begin
      $display("srtf_job_scheduler_core_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, pending.size());
      $display("srtf_job_scheduler_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: srtf_job_scheduler_core.f
+incdir+sv
sv/srtf_pkg.sv
sv/srtf_ifs.sv
sv/srtf_cell.sv
sv/srtf_job_scheduler_core.sv
tb/sv/srtf_job_scheduler_core_tb.sv
